[hw/rtl/gss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gauss-Seidel sweep package
// Shared constants, register indexes and the per-beat control bundle.
// ----------------------------------------------------------------------------
package gss_pkg;

  localparam int unsigned CFG_IDX_BITS   = 2;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam int unsigned GRID_W_BITS    = 11;
  localparam int unsigned GRID_H_BITS    = 16;
  localparam int unsigned GRID_DIM_RESET = 16;
  localparam int unsigned GRID_DIM_MIN   = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1
  } gss_reg_e;

  typedef struct packed {
    logic row0;
    logic flush;
    logic border;
    logic last_col;
  } gss_ctl_t;

endpackage

[hw/rtl/gss_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gauss-Seidel sweep channels
// Valid/ready channels for old cells, new cells and register writes.
// ----------------------------------------------------------------------------
interface gss_in_if #(
  parameter int unsigned DATA_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [DATA_BITS-1:0] old_value;

  modport source (output valid, output old_value, input ready);
  modport sink   (input valid, input old_value, output ready);
endinterface

interface gss_out_if #(
  parameter int unsigned DATA_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [DATA_BITS-1:0] new_value;
  logic                        last_of_grid;

  modport source (output valid, output new_value, output last_of_grid, input ready);
  modport sink   (input valid, input new_value, input last_of_grid, output ready);
endinterface

interface gss_cfg_if;
  import gss_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/gss_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gauss-Seidel sweep raster control
// Holds grid geometry, tracks the raster position and tags each beat.
// ----------------------------------------------------------------------------
module gss_ctrl #(
  parameter int unsigned MAX_WIDTH = 1024,
  localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [gss_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [gss_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                              acc_i,
  output logic [AW-1:0]                     col_o,
  output gss_pkg::gss_ctl_t                 ctl_o
);
  import gss_pkg::*;

  localparam int unsigned RstW = (GRID_DIM_RESET < MAX_WIDTH) ? GRID_DIM_RESET : MAX_WIDTH;

  logic [AW-1:0]          w_last_q, w_last_d;
  logic [GRID_H_BITS-1:0] h_last_q, h_last_d;
  logic [AW-1:0]          col_q, col_d;
  logic [GRID_H_BITS-1:0] row_q, row_d;
  logic                   flush_q, flush_d;
  logic                   restart;
  logic [GRID_W_BITS-1:0] wr_w;
  logic [GRID_H_BITS-1:0] wr_h;

  assign wr_w = cfg_data_i[GRID_W_BITS-1:0];
  assign wr_h = cfg_data_i[GRID_H_BITS-1:0];

  assign col_o          = col_q;
  assign ctl_o.row0     = (row_q == '0);
  assign ctl_o.flush    = flush_q;
  assign ctl_o.last_col = (col_q == w_last_q);
  assign ctl_o.border   = (row_q == GRID_H_BITS'(1)) || (col_q == '0) || ctl_o.last_col;

  always_comb begin
    w_last_d = w_last_q;
    h_last_d = h_last_q;
    col_d    = col_q;
    row_d    = row_q;
    flush_d  = flush_q;
    restart  = 1'b0;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GRID_WIDTH: begin
          restart = 1'b1;
          if (wr_w < GRID_W_BITS'(GRID_DIM_MIN)) begin
            w_last_d = AW'(GRID_DIM_MIN - 1);
          end else if (32'(wr_w) > 32'(MAX_WIDTH)) begin
            w_last_d = AW'(MAX_WIDTH - 1);
          end else begin
            w_last_d = AW'(wr_w - 1'b1);
          end
        end
        REG_GRID_HEIGHT: begin
          restart = 1'b1;
          if (wr_h < GRID_H_BITS'(GRID_DIM_MIN)) begin
            h_last_d = GRID_H_BITS'(GRID_DIM_MIN - 1);
          end else begin
            h_last_d = wr_h - 1'b1;
          end
        end
        default: ;
      endcase
    end else if (acc_i) begin
      if (ctl_o.last_col) begin
        col_d = '0;
        if (ctl_o.row0) begin
          flush_d = 1'b0;
        end
        if (row_q == h_last_q) begin
          row_d   = '0;
          flush_d = 1'b1;
        end else begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end
    if (restart) begin
      col_d   = '0;
      row_d   = '0;
      flush_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q <= AW'(RstW - 1);
      h_last_q <= GRID_H_BITS'(GRID_DIM_RESET - 1);
      col_q    <= '0;
      row_q    <= '0;
      flush_q  <= 1'b0;
    end else begin
      w_last_q <= w_last_d;
      h_last_q <= h_last_d;
      col_q    <= col_d;
      row_q    <= row_d;
      flush_q  <= flush_d;
    end
  end

endmodule

[hw/rtl/gss_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gauss-Seidel sweep datapath
// Row memories, two-stage update pipeline and output register.
// ----------------------------------------------------------------------------
module gss_datapath #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned DATA_BITS = 32,
  localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [DATA_BITS-1:0] old_value_i,
  input  logic [AW-1:0]               col_i,
  input  gss_pkg::gss_ctl_t           ctl_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [DATA_BITS-1:0] new_value_o,
  output logic                        last_of_grid_o
);
  import gss_pkg::*;

  localparam int unsigned SW = DATA_BITS + 2;

  logic [DATA_BITS-1:0] old_mem [MAX_WIDTH];
  logic [DATA_BITS-1:0] new_mem [MAX_WIDTH];

  logic                        acc;
  logic [AW-1:0]               nxt_col;
  logic                        p1_vld_q, p1_vld_d, p2_vld_q, p2_vld_d, out_vld_q, out_vld_d;
  logic                        p1_mv, p1_free, p2_mv, p2_free, out_free, p2_res, wr_new;
  logic signed [DATA_BITS-1:0] p1_cell_q, p1_old_c_q, p1_old_n_q, p1_new_c_q;
  logic [AW-1:0]               p1_col_q, p2_col_q;
  gss_ctl_t                    p1_ctl_q, p2_ctl_q;
  logic signed [SW-1:0]        p2_part_q, part, sum_full, sum_shr;
  logic signed [DATA_BITS-1:0] p2_old_q, left_q, res_val, out_val_q;
  logic                        out_last_q;

  assign nxt_col  = col_i + 1'b1;
  assign out_free = !out_vld_q || out_ready_i;
  assign p2_res   = p2_ctl_q.row0 ? p2_ctl_q.flush : 1'b1;
  assign p2_mv    = p2_vld_q && (out_free || !p2_res);
  assign p2_free  = !p2_vld_q || p2_mv;
  assign p1_mv    = p1_vld_q && p2_free;
  assign p1_free  = !p1_vld_q || p1_mv;
  assign in_ready_o = p1_free;
  assign acc      = in_valid_i && p1_free;
  assign wr_new   = p2_mv && !p2_ctl_q.row0;

  assign p1_vld_d  = acc || (p1_vld_q && !p1_mv);
  assign p2_vld_d  = p1_mv || (p2_vld_q && !p2_mv);
  assign out_vld_d = (p2_mv && p2_res) || (out_vld_q && !out_ready_i);

  assign part     = SW'(p1_new_c_q) + SW'(p1_old_n_q) + SW'(p1_cell_q);
  assign sum_full = p2_part_q + SW'(left_q);
  assign sum_shr  = sum_full >>> 2;
  assign res_val  = (p2_ctl_q.row0 || p2_ctl_q.border) ? p2_old_q : sum_shr[DATA_BITS-1:0];

  assign out_valid_o    = out_vld_q;
  assign new_value_o    = out_val_q;
  assign last_of_grid_o = out_last_q;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      p1_old_c_q       <= old_mem[col_i];
      p1_old_n_q       <= old_mem[nxt_col];
      p1_new_c_q       <= new_mem[col_i];
      old_mem[col_i]   <= old_value_i;
    end
    if (wr_new) begin
      new_mem[p2_col_q] <= res_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      p1_cell_q <= old_value_i;
      p1_col_q  <= col_i;
      p1_ctl_q  <= ctl_i;
    end
    if (p1_mv) begin
      p2_part_q <= part;
      p2_old_q  <= p1_old_c_q;
      p2_col_q  <= p1_col_q;
      p2_ctl_q  <= p1_ctl_q;
    end
    if (p2_mv && p2_res) begin
      out_val_q  <= res_val;
      out_last_q <= p2_ctl_q.row0 && p2_ctl_q.last_col;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      left_q    <= '0;
    end else begin
      p1_vld_q  <= p1_vld_d;
      p2_vld_q  <= p2_vld_d;
      out_vld_q <= out_vld_d;
      if (wr_new) begin
        left_q <= res_val;
      end
    end
  end

endmodule

[hw/rtl/gauss_seidel_stencil_sweep_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gauss-Seidel five-point sweep
// One sweep over a raster stream of signed fixed-point cells.
// ----------------------------------------------------------------------------
// Unless the output stalls, takes one old cell per clock and, once the pipeline
// is primed, gives one new cell per clock, one row behind the input: the first
// row of a grid yields nothing (or the previous grid's last row), later rows
// yield the row above. An accepted beat passes the registered row-memory
// read, a pre-add stage and the final add with the left neighbor into the
// output register. The old-row memory has two read ports and one write port,
// the new-row memory one of each; no clearing pass runs after reset. Width
// and height writes restart the grid at row zero and drop a pending last row.
module gauss_seidel_stencil_sweep_top #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned DATA_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gss_cfg_if.sink   cfg_i,
  gss_in_if.sink    in_i,
  gss_out_if.source out_o
);
  import gss_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic          in_ready;
  logic          acc;
  logic [AW-1:0] col;
  gss_ctl_t      ctl;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign acc         = in_i.valid && in_ready;

  gss_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_i.valid),
    .cfg_index_i(cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .acc_i      (acc),
    .col_o      (col),
    .ctl_o      (ctl)
  );

  gss_datapath #(
    .MAX_WIDTH(MAX_WIDTH),
    .DATA_BITS(DATA_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_ready),
    .old_value_i   (in_i.old_value),
    .col_i         (col),
    .ctl_i         (ctl),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .new_value_o   (out_o.new_value),
    .last_of_grid_o(out_o.last_of_grid)
  );

endmodule

[hw/rtl/gss_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gauss-Seidel sweep port checker
// Concurrent checks on the top-level channels, bound to the top level.
// ----------------------------------------------------------------------------
module gss_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_last_i,
  input logic cfg_ready_i
);

  logic last_beat;

  assign last_beat = out_valid_i && out_ready_i && out_last_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  a_in_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output register");

  a_cfg_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("register write port not ready");

  a_last_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_beat |=> !last_beat)
    else $error("grid end marked on consecutive beats");

  a_in_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i, 2) || $past(!in_ready_i, 2)
      || $past(out_valid_i, 2) || $past(!in_ready_i)
      || $past(in_valid_i, 3) || $past(in_valid_i))
    else $error("output beat without a preceding input beat");

endmodule

bind gauss_seidel_stencil_sweep_top gss_checker u_gss_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_last_i (out_o.last_of_grid),
  .cfg_ready_i(cfg_i.ready)
);

[tb/gss_sweep_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gauss-Seidel sweep checker
// Watches the register, old-cell and new-cell channels and keeps its own copy
// of the raster position, the row stores and the geometry. For every accepted
// old cell it works out the new cell that beat causes, if any, and queues it.
// Each accepted new-cell beat is compared field by field with the oldest
// queued cell. Failures are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module gss_sweep_checker
  import gss_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned DATA_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gss_cfg_if          cfg_i,
  gss_in_if           in_i,
  gss_out_if          out_o,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic signed [DATA_BITS-1:0] new_value;
    logic                        last_of_grid;
  } new_cell_t;

  logic [GRID_W_BITS-1:0]      width_q;
  logic [GRID_H_BITS-1:0]      height_q;
  logic signed [DATA_BITS-1:0] old_row [MAX_WIDTH];
  logic signed [DATA_BITS-1:0] new_row [MAX_WIDTH];
  logic signed [DATA_BITS-1:0] left_new;
  int unsigned                 col_q;
  int unsigned                 row_q;
  logic                        flush_q;
  new_cell_t                   due_cells [$];
  int unsigned                 fail_count;

  assign fail_count_o = fail_count;

  function automatic int unsigned eff_width(input logic [GRID_W_BITS-1:0] w);
    if (w < GRID_DIM_MIN) begin
      return GRID_DIM_MIN;
    end
    if (w > MAX_WIDTH) begin
      return MAX_WIDTH;
    end
    return 32'(w);
  endfunction

  function automatic int unsigned eff_height(input logic [GRID_H_BITS-1:0] h);
    return (h < GRID_DIM_MIN) ? GRID_DIM_MIN : 32'(h);
  endfunction

  // floor of the four-term mean: sum with two guard bits, drop the low two
  function automatic logic signed [DATA_BITS-1:0] quarter_sum(
    input logic signed [DATA_BITS-1:0] a,
    input logic signed [DATA_BITS-1:0] b,
    input logic signed [DATA_BITS-1:0] c,
    input logic signed [DATA_BITS-1:0] d
  );
    logic [DATA_BITS+1:0] total;
    total = {{2{a[DATA_BITS-1]}}, a} + {{2{b[DATA_BITS-1]}}, b}
          + {{2{c[DATA_BITS-1]}}, c} + {{2{d[DATA_BITS-1]}}, d};
    return total[DATA_BITS+1:2];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    new_cell_t                   got;
    new_cell_t                   want;
    int unsigned                 w;
    int unsigned                 h;
    int unsigned                 c;
    int unsigned                 r;
    logic signed [DATA_BITS-1:0] old_cell;
    logic signed [DATA_BITS-1:0] v;
    if (!rst_ni) begin
      width_q  = GRID_W_BITS'(GRID_DIM_RESET);
      height_q = GRID_H_BITS'(GRID_DIM_RESET);
      for (int i = 0; i < MAX_WIDTH; i++) begin
        old_row[i] = '0;
        new_row[i] = '0;
      end
      left_new   = '0;
      col_q      = 0;
      row_q      = 0;
      flush_q    = 1'b0;
      fail_count = 0;
      due_cells.delete();
      pending_o <= 0;
    end else begin
      if (out_o.valid && out_o.ready) begin
        got.new_value    = out_o.new_value;
        got.last_of_grid = out_o.last_of_grid;
        if (due_cells.size() == 0) begin
          $error("unexpected beat: new_value %h last_of_grid %b",
                 got.new_value, got.last_of_grid);
          fail_count++;
        end else begin
          want = due_cells.pop_front();
          if (got.new_value !== want.new_value) begin
            $error("new_value: expected %h, got %h", want.new_value, got.new_value);
            fail_count++;
          end
          if (got.last_of_grid !== want.last_of_grid) begin
            $error("last_of_grid: expected %b, got %b",
                   want.last_of_grid, got.last_of_grid);
            fail_count++;
          end
        end
      end

      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_GRID_WIDTH: begin
            width_q  = cfg_i.data[GRID_W_BITS-1:0];
            left_new = '0;
            col_q    = 0;
            row_q    = 0;
            flush_q  = 1'b0;
          end
          REG_GRID_HEIGHT: begin
            height_q = cfg_i.data[GRID_H_BITS-1:0];
            left_new = '0;
            col_q    = 0;
            row_q    = 0;
            flush_q  = 1'b0;
          end
          default: begin
          end
        endcase
      end

      if (in_i.valid && in_i.ready) begin
        w        = eff_width(width_q);
        h        = eff_height(height_q);
        c        = (col_q >= w) ? w - 1 : col_q;
        r        = (row_q >= h) ? h - 1 : row_q;
        old_cell = in_i.old_value;
        if (r == 0) begin
          if (flush_q) begin
            want.new_value    = old_row[c];
            want.last_of_grid = (c == w - 1);
            due_cells.push_back(want);
          end
        end else begin
          if (r == 1 || c == 0 || c == w - 1) begin
            v = old_row[c];
          end else begin
            v = quarter_sum(new_row[c], left_new, old_cell, old_row[c+1]);
          end
          new_row[c]        = v;
          left_new          = v;
          want.new_value    = v;
          want.last_of_grid = 1'b0;
          due_cells.push_back(want);
        end
        old_row[c] = old_cell;
        c++;
        if (c >= w) begin
          c = 0;
          if (r == 0) begin
            flush_q = 1'b0;
          end
          r++;
          if (r >= h) begin
            r       = 0;
            flush_q = 1'b1;
          end
        end
        col_q = c;
        row_q = r;
      end
      pending_o <= due_cells.size();
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gauss-Seidel sweep testbench
// Streams old grids through the sweep under several geometries and idle
// patterns: a short directed run of 3x3 grids with extreme cells, part of one
// wide grid at the maximum width, then random phases of mostly small grids
// with random register writes between them. A checker beside the block
// predicts every new cell; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import gss_pkg::*;

  localparam int unsigned MAX_WIDTH    = 1024;
  localparam int unsigned DATA_BITS    = 32;
  localparam int unsigned RANDOM_CELLS = 520;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned LIMIT_CYCLES = 400000;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned cur_w;
  int unsigned cur_h;

  gss_cfg_if                          cfg_bus ();
  gss_in_if  #(.DATA_BITS(DATA_BITS)) cell_in ();
  gss_out_if #(.DATA_BITS(DATA_BITS)) cell_out ();

  gauss_seidel_stencil_sweep_top #(
    .MAX_WIDTH(MAX_WIDTH),
    .DATA_BITS(DATA_BITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .in_i  (cell_in),
    .out_o (cell_out)
  );

  gss_sweep_checker #(
    .MAX_WIDTH(MAX_WIDTH),
    .DATA_BITS(DATA_BITS)
  ) i_sweep_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_bus),
    .in_i        (cell_in),
    .out_o       (cell_out),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    cell_out.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    logic [GRID_W_BITS-1:0] w;
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_GRID_WIDTH) begin
      w     = data[GRID_W_BITS-1:0];
      cur_w = (w < GRID_DIM_MIN) ? GRID_DIM_MIN : (w > MAX_WIDTH) ? MAX_WIDTH : w;
    end else if (idx == REG_GRID_HEIGHT) begin
      cur_h = (data < GRID_DIM_MIN) ? GRID_DIM_MIN : data;
    end
  endtask

  task automatic send_cell(input logic signed [DATA_BITS-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      cell_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    cell_in.valid     <= 1'b1;
    cell_in.old_value <= value;
    @(posedge clk_i);
    while (!cell_in.ready) @(posedge clk_i);
  endtask

  // hold the stream until every queued cell has come out
  task automatic hold_for_results();
    cell_in.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    hold_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [DATA_BITS-1:0] random_cell();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic stream_cells(input int unsigned count, input bit hold_mid);
    for (int unsigned i = 0; i < count; i++) begin
      if (hold_mid && i == count / 2) begin
        hold_for_results();
      end
      send_cell(random_cell());
    end
  endtask

  task automatic set_idling(input int unsigned phase);
    case (phase % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 47; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 47; end
      default: begin idle_pct = 38; stall_pct = 38; end
    endcase
  endtask

  initial begin
    int unsigned                 phase;
    int unsigned                 sent;
    int unsigned                 count;
    logic [GRID_W_BITS-1:0]      w;
    logic [CFG_DATA_BITS-1:0]    wdata;
    logic [CFG_DATA_BITS-1:0]    hdata;
    logic signed [DATA_BITS-1:0] floor_grid [9];

    idle_pct          = 0;
    stall_pct         = 0;
    cur_w             = GRID_DIM_RESET;
    cur_h             = GRID_DIM_RESET;
    rst_ni            <= 1'b0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= '0;
    cfg_bus.data      <= '0;
    cell_in.valid     <= 1'b0;
    cell_in.old_value <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 3x3 grids from clamped sizes; spare indexes must not disturb anything
    write_reg(REG_GRID_WIDTH, 16'h0002);
    write_reg(REG_GRID_HEIGHT, 16'h0000);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h5A5A);
    for (int i = 0; i < 9; i++) begin
      send_cell(32'h7FFF_FFFF);
    end
    floor_grid = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                   32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                   32'h8000_0000, 32'h0000_0000, 32'h8000_0000};
    for (int i = 0; i < 9; i++) begin
      send_cell(floor_grid[i]);
    end
    send_cell(32'h0000_0001);
    send_cell(32'h0000_0002);
    send_cell(32'h0000_0003);

    // part of a grid at the maximum width, written above range
    settle();
    set_idling(3);
    write_reg(REG_GRID_WIDTH, 16'hFFFF);
    write_reg(REG_GRID_HEIGHT, 16'h0003);
    stream_cells(cur_w + 8, 1'b0);

    phase = 0;
    sent  = 0;
    while (sent < RANDOM_CELLS) begin
      settle();
      set_idling(phase);
      w     = ($urandom_range(9) < 2) ? GRID_W_BITS'($urandom_range(2))
                                      : GRID_W_BITS'($urandom_range(12, 3));
      wdata = {5'($urandom_range(31)), w};
      case ($urandom_range(19))
        0, 1:    hdata = CFG_DATA_BITS'($urandom_range(2));
        2:       hdata = 16'hFFFF;
        3:       hdata = CFG_DATA_BITS'($urandom);
        default: hdata = CFG_DATA_BITS'($urandom_range(7, 3));
      endcase
      if ($urandom_range(7) == 0) begin
        write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
                  CFG_DATA_BITS'($urandom));
      end
      case ($urandom_range(3))
        0: begin
          write_reg(REG_GRID_WIDTH, wdata);
          write_reg(REG_GRID_HEIGHT, hdata);
        end
        1: begin
          write_reg(REG_GRID_HEIGHT, hdata);
          write_reg(REG_GRID_WIDTH, wdata);
        end
        2:       write_reg(REG_GRID_WIDTH, wdata);
        default: write_reg(REG_GRID_HEIGHT, hdata);
      endcase
      if (cur_h > 8) begin
        count = $urandom_range(4 * cur_w, 1);
      end else begin
        count = cur_w * cur_h * $urandom_range(3, 1) + $urandom_range(2 * cur_w);
      end
      stream_cells(count, (phase % 3 == 1) && count >= 2);
      sent  += count;
      phase++;
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/gss_pkg.sv
hw/rtl/gss_ifs.sv
hw/rtl/gss_ctrl.sv
hw/rtl/gss_datapath.sv
hw/rtl/gauss_seidel_stencil_sweep_top.sv
hw/rtl/gss_checker.sv
tb/gss_sweep_checker.sv
tb/tb.sv
